/* src/fixed_point_matrix_inverse_defines.svh */
// Assertion macros for the matrix inverter.
`ifndef FIXED_POINT_MATRIX_INVERSE_DEFINES_SVH
`define FIXED_POINT_MATRIX_INVERSE_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define FPMI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fpmi assertion failed");
// next-cycle implication
`define FPMI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fpmi assertion failed");
`else
`define FPMI_ASSERT_IMP(lbl, ante, cons)
`define FPMI_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* src/fpmi_pkg.sv */
`default_nettype none
package fpmi_pkg;

    localparam int unsigned DATA_W = 32;
    localparam logic [DATA_W-1:0] FX_ONE = 32'h0001_0000;
    localparam int unsigned DIV_STEPS = 33;

    // sequencer states, one-hot
    typedef enum logic [16:0] {
        ST_LOAD     = 17'h00001,
        ST_SRCH_RD  = 17'h00002,
        ST_SRCH_CHK = 17'h00004,
        ST_PIV      = 17'h00008,
        ST_DIV      = 17'h00010,
        ST_SCL_RD   = 17'h00020,
        ST_SCL_MUL  = 17'h00040,
        ST_SCL_WR   = 17'h00080,
        ST_ELF_RD   = 17'h00100,
        ST_ELF_GET  = 17'h00200,
        ST_EL_RD    = 17'h00400,
        ST_EL_MUL   = 17'h00800,
        ST_EL_WR    = 17'h01000,
        ST_COL      = 17'h02000,
        ST_OUT_RD   = 17'h04000,
        ST_OUT_GET  = 17'h08000,
        ST_OUT_HOLD = 17'h10000
    } state_t;

    // magnitude as unsigned; the most negative value maps to 2^31
    function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] a);
        magnitude = a[DATA_W-1] ? (DATA_W'(0) - a) : a;
    endfunction

endpackage
`default_nettype wire

/* src/fixed_point_matrix_inverse.sv */
// Fixed-point matrix inverter, signed Q15.16, Gauss-Jordan with partial pivoting.
// Input channel s_valid/s_ready/s_element takes one word per cycle, row-major,
// n*n words for a matrix of order n (cfg_we/cfg_wdata set n, only while idle).
// s_ready is high only while loading. After the last word the block inverts in
// place using one shared 32x32 multiplier, one serial divider and one memory
// with two read ports, then emits the n*n inverse words row-major on
// m_valid/m_ready/m_inverse_element, m_last_element marking the final word.
// A zero pivot ends elimination early; then all words are zero with m_singular.
// Setting n only while idle is up to the user; the block does not enforce it.
// Inversion time is set by the read/multiply/write sequence on the memory for
// each element; each output word is read, fetched and then held. A stalled
// receiver holds the output register and the block waits; nothing is dropped.
// No new matrix is taken until the last inverse word is accepted.
// Reset (synchronous, active low) returns to loading with order 8, an empty
// load count and no pending output; the matrix memory is not cleared.
`default_nettype none
`include "fixed_point_matrix_inverse_defines.svh"
module fixed_point_matrix_inverse #(
    parameter int unsigned MAX_ORDER = 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [3:0]          cfg_wdata,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic signed [31:0]  s_element,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [31:0]       m_inverse_element,
    output logic                     m_last_element,
    output logic                     m_singular
);

    localparam int unsigned DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned RW = $clog2(MAX_ORDER);
    localparam int unsigned OW = $clog2(MAX_ORDER + 1);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned DW = fpmi_pkg::DATA_W;

    fpmi_pkg::state_t state_reg;

    logic [3:0]    order_reg;
    logic [OW-1:0] n_use;
    logic [OW-1:0] n_reg;
    logic [RW-1:0] last_idx;
    logic [CW-1:0] load_cnt_reg;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] total;

    logic [RW-1:0] k_reg, r_reg, i_reg, best_reg;
    logic [DW-1:0] bestmag_reg, bestval_reg;
    logic [RW-1:0] ro_reg [MAX_ORDER];
    logic [RW-1:0] col_reg [MAX_ORDER];
    logic          sing_reg;

    // divider
    logic [DW-1:0] rem_reg, dvs_reg;
    logic [DW:0]   quo_reg;
    logic [5:0]    dcnt_reg;
    logic          neg_reg;
    logic [DW:0]   rem_sh;
    logic          div_ge;
    logic [DW-1:0] rem_next;
    logic [DW:0]   quo_next;

    // arithmetic operands
    logic [DW-1:0]        recip_reg, f_reg, a_reg;
    logic signed [63:0]   prod_reg;
    logic [DW-1:0]        srch_mag;

    // memory
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd0_reg, rd1_reg;
    logic [AW-1:0] ra0, ra1, wa;
    logic [DW-1:0] wd;
    logic          we;

    function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] row,
                                              input logic [RW-1:0] col,
                                              input logic [OW-1:0] n);
        logic [AW+OW:0] full;
        full = (AW+OW+1)'(row) * (AW+OW+1)'(n) + (AW+OW+1)'(col);
        addr_of = full[AW-1:0];
    endfunction

    // order in use, clamped
    always_comb begin
        if (order_reg == 4'd0) begin
            n_use = OW'(1);
        end else if (32'(order_reg) > MAX_ORDER) begin
            n_use = OW'(MAX_ORDER);
        end else begin
            n_use = OW'(order_reg);
        end
    end

    assign cnt_inc  = load_cnt_reg + CW'(1);
    assign total    = CW'(CW'(n_use) * CW'(n_use));
    assign last_idx = RW'(n_reg - OW'(1));
    assign srch_mag = fpmi_pkg::magnitude(rd0_reg);

    // one restoring step of 2^32 / |pivot|
    assign rem_sh   = {rem_reg, (dcnt_reg == 6'd0)};
    assign div_ge   = rem_sh >= {1'b0, dvs_reg};
    assign rem_next = div_ge ? DW'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DW-1:0];
    assign quo_next = {quo_reg[DW-1:0], div_ge};

    // memory addresses and write port
    always_comb begin
        ra0 = addr_of(ro_reg[r_reg], k_reg, n_reg);
        ra1 = addr_of(ro_reg[r_reg], i_reg, n_reg);
        wa  = addr_of(ro_reg[r_reg], i_reg, n_reg);
        wd  = a_reg - prod_reg[47:16];
        we  = 1'b0;
        case (state_reg)
            fpmi_pkg::ST_LOAD: begin
                wa = load_cnt_reg[AW-1:0];
                wd = s_element;
                we = s_valid;
            end
            fpmi_pkg::ST_SCL_RD: begin
                ra0 = addr_of(ro_reg[k_reg], i_reg, n_reg);
            end
            fpmi_pkg::ST_SCL_WR: begin
                wa = addr_of(ro_reg[k_reg], i_reg, n_reg);
                wd = prod_reg[47:16];
                we = 1'b1;
            end
            fpmi_pkg::ST_EL_RD: begin
                ra0 = addr_of(ro_reg[k_reg], i_reg, n_reg);
            end
            fpmi_pkg::ST_EL_WR: begin
                we = 1'b1;
            end
            fpmi_pkg::ST_OUT_RD: begin
                ra0 = addr_of(ro_reg[r_reg], col_reg[i_reg], n_reg);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd0_reg <= mem[ra0];
        rd1_reg <= mem[ra1];
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= 4'd8;
        end else if (cfg_we) begin
            order_reg <= cfg_wdata;
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fpmi_pkg::ST_LOAD;
            load_cnt_reg <= '0;
            sing_reg     <= 1'b0;
            m_valid      <= 1'b0;
            for (int q = 0; q < MAX_ORDER; q++) begin
                ro_reg[q] <= RW'(q);
            end
        end else begin
            case (state_reg)
                fpmi_pkg::ST_LOAD: begin
                    if (s_valid) begin
                        if (load_cnt_reg == '0) begin
                            for (int q = 0; q < MAX_ORDER; q++) begin
                                ro_reg[q] <= RW'(q);
                            end
                            sing_reg <= 1'b0;
                        end
                        if (cnt_inc >= total) begin
                            load_cnt_reg <= '0;
                            n_reg        <= n_use;
                            k_reg        <= '0;
                            r_reg        <= '0;
                            state_reg    <= fpmi_pkg::ST_SRCH_RD;
                        end else begin
                            load_cnt_reg <= cnt_inc;
                        end
                    end
                end
                fpmi_pkg::ST_SRCH_RD: begin
                    state_reg <= fpmi_pkg::ST_SRCH_CHK;
                end
                fpmi_pkg::ST_SRCH_CHK: begin
                    // strict compare: topmost row wins a tie
                    if (r_reg == k_reg || srch_mag > bestmag_reg) begin
                        best_reg    <= r_reg;
                        bestmag_reg <= srch_mag;
                        bestval_reg <= rd0_reg;
                    end
                    if (r_reg == last_idx) begin
                        state_reg <= fpmi_pkg::ST_PIV;
                    end else begin
                        r_reg     <= r_reg + RW'(1);
                        state_reg <= fpmi_pkg::ST_SRCH_RD;
                    end
                end
                fpmi_pkg::ST_PIV: begin
                    if (best_reg != k_reg) begin
                        ro_reg[k_reg]    <= ro_reg[best_reg];
                        ro_reg[best_reg] <= ro_reg[k_reg];
                    end
                    if (bestval_reg == '0) begin
                        sing_reg  <= 1'b1;
                        i_reg     <= '0;
                        state_reg <= fpmi_pkg::ST_COL;
                    end else begin
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        dcnt_reg  <= '0;
                        dvs_reg   <= bestmag_reg;
                        neg_reg   <= bestval_reg[DW-1];
                        state_reg <= fpmi_pkg::ST_DIV;
                    end
                end
                fpmi_pkg::ST_DIV: begin
                    rem_reg  <= rem_next;
                    quo_reg  <= quo_next;
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (dcnt_reg == 6'(fpmi_pkg::DIV_STEPS - 1)) begin
                        recip_reg <= neg_reg ? (DW'(0) - quo_next[DW-1:0])
                                             : quo_next[DW-1:0];
                        i_reg     <= '0;
                        state_reg <= fpmi_pkg::ST_SCL_RD;
                    end
                end
                // scale the pivot row; pivot slot counts as one
                fpmi_pkg::ST_SCL_RD: begin
                    state_reg <= fpmi_pkg::ST_SCL_MUL;
                end
                fpmi_pkg::ST_SCL_MUL: begin
                    prod_reg <= $signed((i_reg == k_reg) ? fpmi_pkg::FX_ONE : rd0_reg)
                              * $signed(recip_reg);
                    state_reg <= fpmi_pkg::ST_SCL_WR;
                end
                fpmi_pkg::ST_SCL_WR: begin
                    if (i_reg == last_idx) begin
                        r_reg     <= '0;
                        state_reg <= fpmi_pkg::ST_ELF_RD;
                    end else begin
                        i_reg     <= i_reg + RW'(1);
                        state_reg <= fpmi_pkg::ST_SCL_RD;
                    end
                end
                // elimination: fetch factor of row r
                fpmi_pkg::ST_ELF_RD: begin
                    if (r_reg == k_reg) begin
                        if (r_reg == last_idx) begin
                            if (k_reg == last_idx) begin
                                i_reg     <= '0;
                                state_reg <= fpmi_pkg::ST_COL;
                            end else begin
                                k_reg     <= k_reg + RW'(1);
                                r_reg     <= k_reg + RW'(1);
                                state_reg <= fpmi_pkg::ST_SRCH_RD;
                            end
                        end else begin
                            r_reg <= r_reg + RW'(1);
                        end
                    end else begin
                        state_reg <= fpmi_pkg::ST_ELF_GET;
                    end
                end
                fpmi_pkg::ST_ELF_GET: begin
                    f_reg     <= rd0_reg;
                    i_reg     <= '0;
                    state_reg <= fpmi_pkg::ST_EL_RD;
                end
                fpmi_pkg::ST_EL_RD: begin
                    state_reg <= fpmi_pkg::ST_EL_MUL;
                end
                fpmi_pkg::ST_EL_MUL: begin
                    prod_reg  <= $signed(rd0_reg) * $signed(f_reg);
                    a_reg     <= (i_reg == k_reg) ? '0 : rd1_reg;
                    state_reg <= fpmi_pkg::ST_EL_WR;
                end
                fpmi_pkg::ST_EL_WR: begin
                    if (i_reg != last_idx) begin
                        i_reg     <= i_reg + RW'(1);
                        state_reg <= fpmi_pkg::ST_EL_RD;
                    end else if (r_reg != last_idx) begin
                        r_reg     <= r_reg + RW'(1);
                        state_reg <= fpmi_pkg::ST_ELF_RD;
                    end else if (k_reg != last_idx) begin
                        k_reg     <= k_reg + RW'(1);
                        r_reg     <= k_reg + RW'(1);
                        state_reg <= fpmi_pkg::ST_SRCH_RD;
                    end else begin
                        i_reg     <= '0;
                        state_reg <= fpmi_pkg::ST_COL;
                    end
                end
                // invert the row permutation into a column map
                fpmi_pkg::ST_COL: begin
                    col_reg[ro_reg[i_reg]] <= i_reg;
                    if (i_reg == last_idx) begin
                        r_reg     <= '0;
                        i_reg     <= '0;
                        state_reg <= fpmi_pkg::ST_OUT_RD;
                    end else begin
                        i_reg <= i_reg + RW'(1);
                    end
                end
                fpmi_pkg::ST_OUT_RD: begin
                    state_reg <= fpmi_pkg::ST_OUT_GET;
                end
                fpmi_pkg::ST_OUT_GET: begin
                    m_valid           <= 1'b1;
                    m_inverse_element <= sing_reg ? '0 : rd0_reg;
                    m_singular        <= sing_reg;
                    m_last_element    <= (r_reg == last_idx) && (i_reg == last_idx);
                    state_reg         <= fpmi_pkg::ST_OUT_HOLD;
                end
                fpmi_pkg::ST_OUT_HOLD: begin
                    if (m_ready) begin
                        m_valid <= 1'b0;
                        if (i_reg != last_idx) begin
                            i_reg     <= i_reg + RW'(1);
                            state_reg <= fpmi_pkg::ST_OUT_RD;
                        end else if (r_reg != last_idx) begin
                            i_reg     <= '0;
                            r_reg     <= r_reg + RW'(1);
                            state_reg <= fpmi_pkg::ST_OUT_RD;
                        end else begin
                            state_reg <= fpmi_pkg::ST_LOAD;
                        end
                    end
                end
                default: begin
                    state_reg <= fpmi_pkg::ST_LOAD;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == fpmi_pkg::ST_LOAD);

    // checks
    `FPMI_ASSERT_IMP(a_no_overlap, m_valid, !s_ready)
    `FPMI_ASSERT_IMP(a_singular_zero, m_valid && m_singular, m_inverse_element == 32'sd0)
    `FPMI_ASSERT_NXT(a_back_to_load, m_valid && m_ready && m_last_element, s_ready)

endmodule
`default_nettype wire
